// File: src/gsb_pkg.sv
// package for the gif stream boundary scanner: codes, phases, state types and helpers
package gsb_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  localparam logic [31:0] SIG_WORD    = 32'h47494638;
  localparam logic [15:0] VER_87A     = 16'h3761;
  localparam logic [15:0] VER_89A     = 16'h3961;
  localparam logic [7:0]  INTRO_EXT   = 8'h21;
  localparam logic [7:0]  INTRO_IMG   = 8'h2C;
  localparam logic [7:0]  INTRO_END   = 8'h3B;
  localparam logic [7:0]  LBL_GCE     = 8'hF9;
  localparam logic [7:0]  LBL_COMMENT = 8'hFE;
  localparam logic [7:0]  LBL_APP     = 8'hFF;
  localparam logic [7:0]  LBL_TEXT    = 8'h01;

  localparam logic [9:0]  SIG_LEN     = 10'd6;
  localparam logic [9:0]  LSD_LEN     = 10'd7;
  localparam logic [9:0]  LSD_FLAGS   = 10'd4;
  localparam logic [9:0]  VER_FIRST   = 10'd4;
  localparam logic [9:0]  IMG_DESC_LEN = 10'd8;

  typedef enum logic [1:0] {
    V_OK        = 2'd0,
    V_BAD_SIG   = 2'd1,
    V_BAD_BLOCK = 2'd2,
    V_TRUNC     = 2'd3
  } verdict_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIG, PH_LSD, PH_GCT, PH_BLOCK, PH_EXT_LABEL, PH_EXT_SIZE,
    PH_EXT_BODY, PH_GCE_TERM, PH_SUB_SIZE, PH_SUB_DATA, PH_IMG_DESC,
    PH_IMG_FLAGS, PH_LCT, PH_LZW_MIN
  } phase_t;

  // parse state apart from the byte count, whose width is a parameter
  typedef struct packed {
    phase_t      phase;
    logic [9:0]  field_count;
    logic [7:0]  subblock_left;
    logic        saw_image;
    logic [7:0]  flag_byte;
  } parse_state_t;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
    logic       end_flag;
  } in_word_t;

  // result of one step of the parser
  typedef struct packed {
    logic        valid;
    verdict_t    verdict;
    logic [31:0] total_length;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = SIG_WORD[31:24];
      2'd1:    r = SIG_WORD[23:16];
      2'd2:    r = SIG_WORD[15:8];
      default: r = SIG_WORD[7:0];
    endcase
    return r;
  endfunction

  // bytes in a color table of 2^(n+1) rgb entries
  function automatic logic [9:0] table_bytes(input logic [2:0] n);
    logic [3:0] sh;
    sh = {1'b0, n} + 4'd1;
    return 10'd3 << sh;
  endfunction

endpackage

// File: src/gsb_core.sv
// parser state registers and the single-byte step logic
module gsb_core
  import gsb_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  in_word_t word,
  output result_t  result
);

  parse_state_t           st;
  parse_state_t           st_next;
  logic [LENGTH_BITS-1:0] byte_total;
  logic [LENGTH_BITS-1:0] byte_total_next;

  parse_state_t           cur;
  logic [LENGTH_BITS-1:0] bt;
  logic [LENGTH_BITS-1:0] bt_inc;
  logic [9:0]             fc_dec;
  logic [7:0]             sl_dec;
  logic [7:0]             b;
  logic                   has_v;
  verdict_t               v;

  assign b = word.data_byte;

  always_comb begin
    cur = st;
    bt  = byte_total;
    if (word.start_flag) begin
      cur = '{phase: PH_SIG, field_count: '0, subblock_left: '0,
              saw_image: 1'b0, flag_byte: '0};
      bt  = '0;
    end
    bt_inc = bt + LENGTH_BITS'(1);
    fc_dec = (cur.field_count != '0) ? cur.field_count - 10'd1 : '0;
    sl_dec = (cur.subblock_left != '0) ? cur.subblock_left - 8'd1 : '0;

    st_next         = cur;
    byte_total_next = bt_inc;
    has_v           = 1'b0;
    v               = V_OK;

    case (cur.phase)
      PH_SIG: begin
        st_next.field_count = cur.field_count + 10'd1;
        if (cur.field_count < VER_FIRST) begin
          if (b != sig_byte(cur.field_count[1:0])) begin
            has_v = 1'b1;
            v     = V_BAD_SIG;
          end
        end else if (cur.field_count == VER_FIRST) begin
          st_next.flag_byte = b;
        end else if ({cur.flag_byte, b} != VER_87A && {cur.flag_byte, b} != VER_89A) begin
          has_v = 1'b1;
          v     = V_BAD_SIG;
        end
        if (st_next.field_count >= SIG_LEN) begin
          st_next.field_count = '0;
          st_next.flag_byte   = '0;
          st_next.phase       = PH_LSD;
        end
      end
      PH_LSD: begin
        if (cur.field_count == LSD_FLAGS) st_next.flag_byte = b;
        st_next.field_count = cur.field_count + 10'd1;
        if (st_next.field_count >= LSD_LEN) begin
          if (st_next.flag_byte[7]) begin
            st_next.field_count = table_bytes(st_next.flag_byte[2:0]);
            st_next.phase       = PH_GCT;
          end else begin
            st_next.field_count = '0;
            st_next.phase       = PH_BLOCK;
          end
        end
      end
      PH_GCT, PH_LCT: begin
        st_next.field_count = fc_dec;
        if (fc_dec == '0) st_next.phase = (cur.phase == PH_GCT) ? PH_BLOCK : PH_LZW_MIN;
      end
      PH_BLOCK: begin
        if (b == INTRO_EXT) begin
          st_next.phase = PH_EXT_LABEL;
        end else if (b == INTRO_IMG) begin
          st_next.saw_image   = 1'b1;
          st_next.field_count = IMG_DESC_LEN;
          st_next.phase       = PH_IMG_DESC;
        end else if (b == INTRO_END) begin
          has_v = 1'b1;
          v     = cur.saw_image ? V_OK : V_BAD_BLOCK;
        end else begin
          has_v = 1'b1;
          v     = V_BAD_BLOCK;
        end
      end
      PH_EXT_LABEL: begin
        if (b == LBL_TEXT || b == LBL_APP || b == LBL_GCE) begin
          st_next.flag_byte = b;
          st_next.phase     = PH_EXT_SIZE;
        end else if (b == LBL_COMMENT) begin
          st_next.phase = PH_SUB_SIZE;
        end else begin
          has_v = 1'b1;
          v     = V_BAD_BLOCK;
        end
      end
      PH_EXT_SIZE: begin
        if (b == '0) begin
          st_next.phase = (cur.flag_byte == LBL_GCE) ? PH_GCE_TERM : PH_SUB_SIZE;
        end else begin
          st_next.field_count = {2'b00, b};
          st_next.phase       = PH_EXT_BODY;
        end
      end
      PH_EXT_BODY: begin
        st_next.field_count = fc_dec;
        if (fc_dec == '0) begin
          st_next.phase = (cur.flag_byte == LBL_GCE) ? PH_GCE_TERM : PH_SUB_SIZE;
        end
      end
      PH_GCE_TERM: begin
        if (b != '0) begin
          has_v = 1'b1;
          v     = V_BAD_BLOCK;
        end else begin
          st_next.phase = PH_BLOCK;
        end
      end
      PH_SUB_SIZE: begin
        if (b == '0) begin
          st_next.phase = PH_BLOCK;
        end else begin
          st_next.subblock_left = b;
          st_next.phase         = PH_SUB_DATA;
        end
      end
      PH_SUB_DATA: begin
        st_next.subblock_left = sl_dec;
        if (sl_dec == '0) st_next.phase = PH_SUB_SIZE;
      end
      PH_IMG_DESC: begin
        st_next.field_count = fc_dec;
        if (fc_dec == '0) st_next.phase = PH_IMG_FLAGS;
      end
      PH_IMG_FLAGS: begin
        if (b[7]) begin
          st_next.field_count = table_bytes(b[2:0]);
          st_next.phase       = PH_LCT;
        end else begin
          st_next.phase = PH_LZW_MIN;
        end
      end
      PH_LZW_MIN: begin
        st_next.phase = PH_SUB_SIZE;
      end
      default: begin
        st_next.phase = PH_IDLE;
      end
    endcase

    // idle: ignore the byte entirely
    if (cur.phase == PH_IDLE) begin
      st_next         = cur;
      byte_total_next = bt;
      has_v           = 1'b0;
    end else if (bt == {LENGTH_BITS{1'b1}}) begin
      // count saturated: too long
      has_v = 1'b1;
      v     = V_TRUNC;
    end else if (!has_v && word.end_flag) begin
      has_v = 1'b1;
      v     = V_TRUNC;
    end

    result.valid        = step && has_v;
    result.verdict      = v;
    result.total_length = (v == V_OK) ? 32'(byte_total_next) : 32'd0;

    if (has_v) begin
      st_next         = '{phase: PH_IDLE, field_count: '0, subblock_left: '0,
                          saw_image: 1'b0, flag_byte: '0};
      byte_total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{phase: PH_IDLE, field_count: '0, subblock_left: '0,
                      saw_image: 1'b0, flag_byte: '0};
      byte_total <= '0;
    end else if (step) begin
      st         <= st_next;
      byte_total <= byte_total_next;
    end
  end

`ifndef ASSERT_OFF
  a_result_goes_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> st.phase == PH_IDLE && byte_total == '0)
    else $error("parser did not go idle after a verdict");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> byte_total == '0)
    else $error("byte count nonzero while idle");

  a_fail_no_length: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.verdict != V_OK |-> result.total_length == 32'd0)
    else $error("length reported with a failing verdict");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(st) && $stable(byte_total))
    else $error("parser state moved without a step");
`endif

endmodule

// File: src/gif_stream_boundary_scanner.sv
// top level of the gif stream boundary scanner: input register, parser, result register
//
//  channel | dir | tdata                         | tuser      | tlast
//  s_      | in  | [7:0] data_byte               | start_flag | end_flag
//  m_      | out | [1:0] verdict, [33:2] length  | -          | -
//
// one input word is parsed per cycle unless the result side stalls; a word waits in the input
// register until it is parsed and its verdict, if any, sits in the result register the next cycle
// a word accepted on the input passes through the input register and then the result
// register before its verdict shows on m_tvalid
// the parser advances only when the result register is empty or being drained,
// so a stall on the result side holds the input register and then s_tready
// synchronous active-high reset clears the parser to idle and drops both registers
module gif_stream_boundary_scanner
  import gsb_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte [7:0]
  input  logic        s_tuser,   // start_flag
  input  logic        s_tlast,   // end_flag
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // verdict [1:0], total_length [33:2], zero [39:34]
);

  // input register
  logic     in_valid;
  in_word_t in_word;

  // result register
  logic        out_valid;
  verdict_t    out_verdict;
  logic [31:0] out_length;

  logic    advance;
  result_t res;

  // parser takes the held word when the result slot can take its verdict
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word <= '{data_byte: s_tdata, start_flag: s_tuser, end_flag: s_tlast};
    end
  end

  gsb_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (in_word),
    .result (res)
  );

  // result slot: refill from the parser or empty once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_verdict <= res.verdict;
      out_length  <= res.total_length;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_length, out_verdict};

endmodule

// File: bench/tb.sv
// testbench for the gif stream boundary scanner: verdict scoreboard, stream drivers and checks
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 26;
  localparam int ITEMS        = 650;
  localparam int CALM_FIRST   = 250;
  localparam int CALM_LAST    = 400;
  localparam logic [63:0] COUNT_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

  // one expected result word
  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] length;
  } scan_result_t;

  // tracks the parse of the byte stream and holds the verdicts still owed
  class verdict_scoreboard;
    phase_t       phase;
    logic [9:0]   fcount;
    logic [7:0]   sub_left;
    bit           saw_image;
    logic [7:0]   held_byte;
    logic [63:0]  byte_count;
    scan_result_t expected_q[$];
    int           errors;

    function new();
      clear_parse();
      errors = 0;
    endfunction

    function void clear_parse();
      phase = PH_IDLE;
      fcount = '0;
      sub_left = '0;
      saw_image = 1'b0;
      held_byte = '0;
      byte_count = '0;
    endfunction

    // advance the parse by one byte; -1 while the candidate goes on, else a verdict
    function int parse_byte(logic [7:0] b);
      logic [15:0] ver;
      int v;
      v = -1;
      case (phase)
        PH_SIG: begin
          if (fcount < 10'd4) begin
            if (b != SIG_WORD[8 * (3 - int'(fcount)) +: 8]) v = V_BAD_SIG;
          end else if (fcount == 10'd4) begin
            held_byte = b;
          end else begin
            ver = {held_byte, b};
            if (ver != VER_87A && ver != VER_89A) v = V_BAD_SIG;
          end
          fcount++;
          if (fcount >= 10'd6) begin
            fcount = '0;
            held_byte = '0;
            phase = PH_LSD;
          end
        end
        PH_LSD: begin
          if (fcount == 10'd4) held_byte = b;
          fcount++;
          if (fcount >= 10'd7) begin
            if (held_byte[7]) begin
              fcount = 10'd3 << (held_byte[2:0] + 4'd1);
              phase = PH_GCT;
            end else begin
              fcount = '0;
              phase = PH_BLOCK;
            end
          end
        end
        PH_GCT, PH_LCT: begin
          if (fcount > 0) fcount--;
          if (fcount == 0) phase = (phase == PH_GCT) ? PH_BLOCK : PH_LZW_MIN;
        end
        PH_BLOCK: begin
          if (b == INTRO_EXT) begin
            phase = PH_EXT_LABEL;
          end else if (b == INTRO_IMG) begin
            saw_image = 1'b1;
            fcount = 10'd8;
            phase = PH_IMG_DESC;
          end else if (b == INTRO_END) begin
            v = saw_image ? V_OK : V_BAD_BLOCK;
          end else begin
            v = V_BAD_BLOCK;
          end
        end
        PH_EXT_LABEL: begin
          if (b == LBL_TEXT || b == LBL_APP || b == LBL_GCE) begin
            held_byte = b;
            phase = PH_EXT_SIZE;
          end else if (b == LBL_COMMENT) begin
            phase = PH_SUB_SIZE;
          end else begin
            v = V_BAD_BLOCK;
          end
        end
        PH_EXT_SIZE: begin
          if (b == 8'd0) begin
            phase = (held_byte == LBL_GCE) ? PH_GCE_TERM : PH_SUB_SIZE;
          end else begin
            fcount = {2'b00, b};
            phase = PH_EXT_BODY;
          end
        end
        PH_EXT_BODY: begin
          if (fcount > 0) fcount--;
          if (fcount == 0) phase = (held_byte == LBL_GCE) ? PH_GCE_TERM : PH_SUB_SIZE;
        end
        PH_GCE_TERM: begin
          if (b != 8'd0) v = V_BAD_BLOCK;
          else phase = PH_BLOCK;
        end
        PH_SUB_SIZE: begin
          if (b == 8'd0) begin
            phase = PH_BLOCK;
          end else begin
            sub_left = b;
            phase = PH_SUB_DATA;
          end
        end
        PH_SUB_DATA: begin
          if (sub_left > 0) sub_left--;
          if (sub_left == 0) phase = PH_SUB_SIZE;
        end
        PH_IMG_DESC: begin
          if (fcount > 0) fcount--;
          if (fcount == 0) phase = PH_IMG_FLAGS;
        end
        PH_IMG_FLAGS: begin
          if (b[7]) begin
            fcount = 10'd3 << (b[2:0] + 4'd1);
            phase = PH_LCT;
          end else begin
            phase = PH_LZW_MIN;
          end
        end
        PH_LZW_MIN: phase = PH_SUB_SIZE;
        default: phase = PH_IDLE;
      endcase
      return v;
    endfunction

    // an input word was accepted
    function void note_word(logic [7:0] b, logic first, logic last);
      scan_result_t r;
      int v;
      if (first) begin
        clear_parse();
        phase = PH_SIG;
      end
      if (phase == PH_IDLE) return;
      if (byte_count >= COUNT_MAX) begin
        v = V_TRUNC;
      end else begin
        byte_count++;
        v = parse_byte(b);
        if (v < 0 && last) v = V_TRUNC;
      end
      if (v >= 0) begin
        r.verdict = verdict_t'(v);
        r.length = (v == V_OK) ? byte_count[31:0] : 32'd0;
        expected_q.push_back(r);
        clear_parse();
      end
    endfunction

    // a result word was accepted
    function void check_result(logic [39:0] word);
      scan_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: verdict %0d length %0d", $time,
                 word[1:0], word[33:2]);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (word[1:0] != want.verdict) begin
        $display("%0t: verdict mismatch: expected %0d actual %0d", $time,
                 want.verdict, word[1:0]);
        errors++;
      end
      if (word[33:2] != want.length) begin
        $display("%0t: length mismatch: expected %0d actual %0d", $time,
                 want.length, word[33:2]);
        errors++;
      end
      if (word[39:34] != 6'd0) begin
        $display("%0t: pad bits mismatch: expected 0 actual %0h", $time, word[39:34]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte [7:0]
  logic        s_tuser;   // start_flag
  logic        s_tlast;   // end_flag
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // verdict [1:0], total_length [33:2], zero [39:34]

  verdict_scoreboard sb = new;

  int   src_idle_pct;
  int   sink_idle_pct;
  bit   hold_req;
  int   cycle_count = 0;
  int   words_sent = 0;
  logic [7:0] gif_bytes[$];

  gif_stream_boundary_scanner dut (
    .clk,
    .rst,
    .s_tvalid,
    .s_tready,
    .s_tdata,
    .s_tuser,
    .s_tlast,
    .m_tvalid,
    .m_tready,
    .m_tdata
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // both handshakes are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // result side: random stalls, or a long hold-off when the stimulus asks for one
  initial begin : result_side
    bit ready_next;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_tready = 1'b0;
        end
      end else begin
        ready_next = ($urandom_range(99) >= sink_idle_pct);
        @(negedge clk);
        m_tready = ready_next;
      end
    end
  end

  // offer one word at the falling edge and hold it until it is taken
  task automatic send_word(input logic [7:0] data, input logic first, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = data;
    s_tuser = first;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // signature with the given version, start flag on the first byte
  task automatic send_sig(input logic [15:0] ver);
    send_word(SIG_WORD[31:24], 1'b1, 1'b0);
    send_word(SIG_WORD[23:16], 1'b0, 1'b0);
    send_word(SIG_WORD[15:8], 1'b0, 1'b0);
    send_word(SIG_WORD[7:0], 1'b0, 1'b0);
    send_word(ver[15:8], 1'b0, 1'b0);
    send_word(ver[7:0], 1'b0, 1'b0);
  endtask

  // signature plus a screen descriptor with every flag bit but the table bit set
  task automatic send_header();
    send_sig(VER_87A);
    for (int i = 0; i < 7; i++) send_word((i == 4) ? 8'h7F : 8'hFF, 1'b0, 1'b0);
  endtask

  function automatic void add_random(int n);
    repeat (n) gif_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // mostly tiny color tables, now and then a mid-size one
  function automatic logic [2:0] pick_table_size();
    if ($urandom_range(19) == 0) return 3'($urandom_range(2, 4));
    return 3'($urandom_range(1));
  endfunction

  // chain of data sub-blocks closed by a zero size byte
  function automatic void add_subblocks();
    int sz;
    repeat ($urandom_range(3)) begin
      sz = ($urandom_range(19) == 0) ? $urandom_range(24, 40) : $urandom_range(1, 4);
      gif_bytes.push_back(8'(sz));
      add_random(sz);
    end
    gif_bytes.push_back(8'h00);
  endfunction

  function automatic void add_extension();
    logic [7:0] lbl;
    int sz;
    case ($urandom_range(3))
      0: lbl = LBL_GCE;
      1: lbl = LBL_COMMENT;
      2: lbl = LBL_APP;
      default: lbl = LBL_TEXT;
    endcase
    gif_bytes.push_back(INTRO_EXT);
    gif_bytes.push_back(lbl);
    if (lbl == LBL_COMMENT) begin
      add_subblocks();
    end else begin
      if (lbl == LBL_GCE) sz = ($urandom_range(3) == 0) ? $urandom_range(6) : 4;
      else if ($urandom_range(29) == 0) sz = $urandom_range(16, 32);
      else sz = $urandom_range(12);
      gif_bytes.push_back(8'(sz));
      add_random(sz);
      if (lbl == LBL_GCE) gif_bytes.push_back(8'h00);
      else add_subblocks();
    end
  endfunction

  function automatic void add_image();
    logic [7:0] flags;
    gif_bytes.push_back(INTRO_IMG);
    add_random(8);
    flags = 8'($urandom_range(255));
    if (flags[7]) flags[2:0] = pick_table_size();
    gif_bytes.push_back(flags);
    if (flags[7]) add_random(3 << (int'(flags[2:0]) + 1));
    gif_bytes.push_back(8'($urandom_range(2, 8)));
    add_subblocks();
  endfunction

  // a file with random content, well-formed apart from the odd one with no image
  function automatic void build_gif();
    logic [15:0] ver;
    logic [7:0] flags;
    bit has_image;
    gif_bytes.delete();
    ver = $urandom_range(1) ? VER_89A : VER_87A;
    gif_bytes.push_back(SIG_WORD[31:24]);
    gif_bytes.push_back(SIG_WORD[23:16]);
    gif_bytes.push_back(SIG_WORD[15:8]);
    gif_bytes.push_back(SIG_WORD[7:0]);
    gif_bytes.push_back(ver[15:8]);
    gif_bytes.push_back(ver[7:0]);
    add_random(4);
    flags = 8'($urandom_range(255));
    if (flags[7]) flags[2:0] = pick_table_size();
    gif_bytes.push_back(flags);
    add_random(2);
    if (flags[7]) add_random(3 << (int'(flags[2:0]) + 1));
    has_image = 1'b0;
    repeat ($urandom_range(3)) begin
      if ($urandom_range(2) == 0) begin
        add_extension();
      end else begin
        add_image();
        has_image = 1'b1;
      end
    end
    // a file with no image now and then, so the early trailer shows up
    if (!has_image && $urandom_range(7) != 0) add_image();
    gif_bytes.push_back(INTRO_END);
  endfunction

  // one candidate: mostly clean, otherwise corrupted, cut short or noise
  task automatic send_candidate();
    int cut;
    int junk;
    bit end_last;
    build_gif();
    case ($urandom_range(9))
      0: gif_bytes[$urandom_range(gif_bytes.size() - 1)] = 8'($urandom_range(255));
      1: begin
        cut = $urandom_range(1, gif_bytes.size());
        while (gif_bytes.size() > cut) void'(gif_bytes.pop_back());
      end
      2: begin
        cut = $urandom_range(1, gif_bytes.size() - 1);
        for (int i = cut; i < gif_bytes.size(); i++) gif_bytes[i] = 8'($urandom_range(255));
      end
      3: begin
        gif_bytes.delete();
        add_random($urandom_range(1, 8));
      end
      default: ;
    endcase
    end_last = 1'($urandom_range(1));
    for (int i = 0; i < gif_bytes.size(); i++)
      send_word(gif_bytes[i], i == 0, end_last && (i == gif_bytes.size() - 1));
    // stray words after the candidate, parsed only while it is still open
    junk = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (junk) send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
  endtask

  initial begin
    int cand;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    src_idle_pct = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // words with no start flag while idle are ignored
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    // bad first byte, end flag on the same byte loses to the error
    send_word(8'hFF, 1'b1, 1'b1);
    // unknown version
    send_sig(16'h3861);
    // end of data inside the signature
    send_word(SIG_WORD[31:24], 1'b1, 1'b0);
    send_word(SIG_WORD[23:16], 1'b0, 1'b1);
    // a new start drops the candidate in progress
    send_word(SIG_WORD[31:24], 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    // trailer before any image
    send_header();
    send_word(INTRO_END, 1'b0, 1'b0);
    // unknown extension label
    send_header();
    send_word(INTRO_EXT, 1'b0, 1'b0);
    send_word(8'h02, 1'b0, 1'b0);
    // graphic control block whose terminator is not zero
    send_header();
    send_word(INTRO_EXT, 1'b0, 1'b0);
    send_word(LBL_GCE, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h07, 1'b0, 1'b0);
    wait_for_results();

    // result side held off while one-word bad candidates keep coming,
    // so the result and input registers fill and the input stalls
    hold_req = 1'b1;
    repeat (10) send_word(8'($urandom_range(8'h46)), 1'b1, 1'b0);
    s_tvalid = 1'b0;
    wait_for_results();

    cand = 0;
    while (words_sent < ITEMS) begin
      // a stretch of words with no idling on either side
      if (words_sent >= CALM_FIRST && words_sent < CALM_LAST) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
      end
      send_candidate();
      if (cand % 6 == 5) begin
        s_tvalid = 1'b0;
        wait_for_results();
      end
      cand++;
    end
    s_tvalid = 1'b0;

    wait_for_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
